[src/nsc_pkg.sv]
// Shared types and constants for the NMEA sentence capture unit.
package nsc_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [2:0] NO_SLOT  = 3'd4;
  localparam int         PAT_W    = 56;
  localparam int         SLOTS_MAX = 4;

  localparam logic [3:0] REG_PATTERN_A = 4'd0;
  localparam logic [3:0] REG_PATTERN_B = 4'd1;
  localparam logic [3:0] REG_PATTERN_C = 4'd2;
  localparam logic [3:0] REG_PATTERN_D = 4'd3;
  localparam logic [3:0] REG_LENGTH_A  = 4'd4;
  localparam logic [3:0] REG_LENGTH_B  = 4'd5;
  localparam logic [3:0] REG_LENGTH_C  = 4'd6;
  localparam logic [3:0] REG_LENGTH_D  = 4'd7;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  rx_byte;
    logic        is_start;
    logic        is_lf;
    logic [1:0]  slot;
    logic        slot_ok;
    logic [7:0]  offset;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        slot_ready;
    logic [3:0]  ready_bits;
    logic        sentence_end;
    logic [2:0]  stored_slot;
    logic        overrun;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [3:0]       index;
    logic [PAT_W-1:0] data;
  } cfg_wr_t;

endpackage

[src/nsc_ram.sv]
// Generic simple dual-port RAM with registered read.
module nsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/nsc_front.sv]
// Front end: accepts input words, classifies them and queues commands.
module nsc_front #(
  parameter int SLOT_COUNT = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [23:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  output logic          cmd_valid,
  output nsc_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  nsc_pkg::cmd_t mem_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    count_r;
  logic          push;
  nsc_pkg::cmd_t cls;

  always_comb begin
    cls.mode     = nsc_pkg::mode_t'(in_tuser);
    cls.rx_byte  = in_tdata[7:0];
    cls.is_start = (in_tdata[7:0] == nsc_pkg::CH_START);
    cls.is_lf    = (in_tdata[7:0] == nsc_pkg::CH_LF);
    cls.slot     = in_tdata[9:8];
    cls.slot_ok  = ({1'b0, in_tdata[9:8]} < 3'(SLOT_COUNT));
    cls.offset   = in_tdata[17:10];
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cls;
    end
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (cmd_pop) rptr_r <= ~rptr_r;
      count_r <= count_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

[src/nsc_back.sv]
// Back end: sentence collection, end-of-sentence match scan, slot copy, reads and clears.
module nsc_back #(
  parameter int LINE_BYTES    = 256,
  parameter int SLOT_COUNT    = 4,
  parameter int PATTERN_CHARS = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nsc_pkg::cfg_wr_t cfg,
  input  logic             cmd_valid,
  input  nsc_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output nsc_pkg::res_t    out_res
);

  localparam int LAW = $clog2(LINE_BYTES);
  localparam int SAW = $clog2(SLOT_COUNT * LINE_BYTES);
  localparam int LCW = $clog2(LINE_BYTES + 1);
  localparam int SW  = $clog2(LINE_BYTES + 2);
  localparam int HCW = $clog2(PATTERN_CHARS + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_PICK, S_COPY} state_t;

  state_t state_r;

  logic [nsc_pkg::PAT_W-1:0] pat_r [nsc_pkg::SLOTS_MAX];
  logic [2:0]                len_r [nsc_pkg::SLOTS_MAX];

  logic [LCW-1:0] line_cnt_r;
  logic           in_sent_r;
  logic [7:0]     last_r;
  logic           ovf_r;
  logic [LCW-1:0] slot_len_r [nsc_pkg::SLOTS_MAX];
  logic [3:0]     ready_r;

  logic          out_valid_r;
  nsc_pkg::res_t out_res_r;
  logic          pend_sready_r;

  // match scan pipeline
  logic [SW-1:0]  iss_r;
  logic           s1_valid_r, s1_lf_r, s2_valid_r;
  logic [7:0]     hist_r [PATTERN_CHARS];
  logic [HCW-1:0] hist_cnt_r;
  logic [3:0]     hit_r;
  logic [3:0]     hit_now;

  // copy pipeline
  logic [LCW-1:0] ci_r, copy_len_r, c1_idx_r;
  logic           c1_valid_r;
  logic [SAW-1:0] copy_base_r;
  logic [1:0]     copy_slot_r;

  logic           free, take, end_hit;
  logic           pick_found;
  logic [1:0]     pick_slot;

  logic           line_we;
  logic [LAW-1:0] line_waddr, line_raddr;
  logic [7:0]     line_rdata;
  logic           slot_we;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  logic [7:0]     slot_rdata;

  assign free    = !out_valid_r || out_tready;
  assign take    = (state_r == S_IDLE) && cmd_valid && free;
  assign cmd_pop = take;
  assign end_hit = in_sent_r && cmd.is_lf && (last_r == nsc_pkg::CH_CR);

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  assign line_we    = take && (cmd.mode == nsc_pkg::MODE_RX) &&
                      (cmd.is_start ||
                       (in_sent_r && !end_hit && (line_cnt_r < LCW'(LINE_BYTES))));
  assign line_waddr = cmd.is_start ? '0 : LAW'(line_cnt_r);
  assign line_raddr = (state_r == S_COPY) ? LAW'(ci_r) : LAW'(iss_r);

  assign slot_we    = (state_r == S_COPY) && c1_valid_r;
  assign slot_waddr = copy_base_r + SAW'(c1_idx_r);
  assign slot_raddr = SAW'(SAW'(cmd.slot) * SAW'(LINE_BYTES)) + SAW'(cmd.offset);

  nsc_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (cmd.rx_byte),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  nsc_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT * LINE_BYTES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (line_rdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // hist_r[m] holds the window byte m places back; it must equal identifier byte m
  always_comb begin
    logic [3:0] eff;
    logic       ok;
    for (int s = 0; s < nsc_pkg::SLOTS_MAX; s++) begin
      eff = (4'(len_r[s]) > 4'(PATTERN_CHARS)) ? 4'(PATTERN_CHARS) : 4'(len_r[s]);
      ok  = (eff != 4'd0) && (4'(hist_cnt_r) >= eff);
      for (int m = 0; m < PATTERN_CHARS; m++) begin
        if ((4'(m) < eff) && (hist_r[m] != 8'(pat_r[s] >> (8 * m)))) ok = 1'b0;
      end
      hit_now[s] = ok;
    end
  end

  always_comb begin
    pick_found = 1'b0;
    pick_slot  = 2'd0;
    for (int s = nsc_pkg::SLOTS_MAX - 1; s >= 0; s--) begin
      if (hit_r[s] && (s < SLOT_COUNT)) begin
        pick_found = 1'b1;
        pick_slot  = 2'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pat_r[0]    <= 56'd4671297;
      pat_r[1]    <= 56'd5915713;
      pat_r[2]    <= 56'd22603022570893361;
      pat_r[3]    <= 56'd5393731;
      len_r[0]    <= 3'd3;
      len_r[1]    <= 3'd3;
      len_r[2]    <= 3'd7;
      len_r[3]    <= 3'd3;
      line_cnt_r  <= '0;
      in_sent_r   <= 1'b0;
      last_r      <= 8'd0;
      ovf_r       <= 1'b0;
      for (int s = 0; s < nsc_pkg::SLOTS_MAX; s++) slot_len_r[s] <= '0;
      ready_r     <= 4'd0;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      c1_valid_r  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          nsc_pkg::REG_PATTERN_A: pat_r[0] <= cfg.data;
          nsc_pkg::REG_PATTERN_B: pat_r[1] <= cfg.data;
          nsc_pkg::REG_PATTERN_C: pat_r[2] <= cfg.data;
          nsc_pkg::REG_PATTERN_D: pat_r[3] <= cfg.data;
          nsc_pkg::REG_LENGTH_A:  len_r[0] <= cfg.data[2:0];
          nsc_pkg::REG_LENGTH_B:  len_r[1] <= cfg.data[2:0];
          nsc_pkg::REG_LENGTH_C:  len_r[2] <= cfg.data[2:0];
          nsc_pkg::REG_LENGTH_D:  len_r[3] <= cfg.data[2:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (take) begin
            out_res_r.read_byte    <= 8'd0;
            out_res_r.slot_ready   <= 1'b0;
            out_res_r.ready_bits   <= ready_r;
            out_res_r.sentence_end <= 1'b0;
            out_res_r.stored_slot  <= nsc_pkg::NO_SLOT;
            out_res_r.overrun      <= 1'b0;
            out_valid_r            <= 1'b1;
            case (cmd.mode)
              nsc_pkg::MODE_RX: begin
                if (cmd.is_start) begin
                  line_cnt_r <= LCW'(1);
                  ovf_r      <= 1'b0;
                  in_sent_r  <= 1'b1;
                  last_r     <= cmd.rx_byte;
                end else if (in_sent_r) begin
                  last_r <= cmd.rx_byte;
                  if (end_hit) begin
                    if (ovf_r) begin
                      out_res_r.sentence_end <= 1'b1;
                      out_res_r.overrun      <= 1'b1;
                      in_sent_r  <= 1'b0;
                      line_cnt_r <= '0;
                      ovf_r      <= 1'b0;
                    end else begin
                      // result is held back until the scan and any copy finish
                      out_valid_r <= 1'b0;
                      state_r     <= S_SCAN;
                      iss_r       <= '0;
                      s1_valid_r  <= 1'b0;
                      s2_valid_r  <= 1'b0;
                      hist_cnt_r  <= '0;
                      hit_r       <= 4'd0;
                    end
                  end else if (line_cnt_r < LCW'(LINE_BYTES)) begin
                    line_cnt_r <= line_cnt_r + LCW'(1);
                  end else begin
                    ovf_r <= 1'b1;
                  end
                end
              end
              nsc_pkg::MODE_READ: begin
                if (cmd.slot_ok) begin
                  out_res_r.slot_ready <= ready_r[cmd.slot];
                  if ({{LCW{1'b0}}, cmd.offset} < {8'd0, slot_len_r[cmd.slot]}) begin
                    pend_sready_r <= ready_r[cmd.slot];
                    out_valid_r   <= 1'b0;
                    state_r       <= S_READ;
                  end
                end
              end
              nsc_pkg::MODE_CLEAR: begin
                if (cmd.slot_ok) begin
                  out_res_r.slot_ready <= ready_r[cmd.slot];
                  ready_r[cmd.slot]    <= 1'b0;
                  out_res_r.ready_bits <= ready_r & ~(4'd1 << cmd.slot);
                end
              end
              default: ;
            endcase
          end
        end

        S_READ: begin
          out_res_r.read_byte    <= slot_rdata;
          out_res_r.slot_ready   <= pend_sready_r;
          out_res_r.ready_bits   <= ready_r;
          out_res_r.sentence_end <= 1'b0;
          out_res_r.stored_slot  <= nsc_pkg::NO_SLOT;
          out_res_r.overrun      <= 1'b0;
          out_valid_r            <= 1'b1;
          state_r                <= S_IDLE;
        end

        S_SCAN: begin
          // window is the stored bytes followed by the closing LF
          if (iss_r <= SW'(line_cnt_r)) begin
            s1_valid_r <= 1'b1;
            s1_lf_r    <= (iss_r == SW'(line_cnt_r));
            iss_r      <= iss_r + SW'(1);
          end else begin
            s1_valid_r <= 1'b0;
          end
          if (s1_valid_r) begin
            hist_r[0] <= s1_lf_r ? nsc_pkg::CH_LF : line_rdata;
            for (int m = 1; m < PATTERN_CHARS; m++) hist_r[m] <= hist_r[m-1];
            if (hist_cnt_r != HCW'(PATTERN_CHARS)) hist_cnt_r <= hist_cnt_r + HCW'(1);
          end
          s2_valid_r <= s1_valid_r;
          if (s2_valid_r) hit_r <= hit_r | hit_now;
          if ((iss_r > SW'(line_cnt_r)) && !s1_valid_r && !s2_valid_r) state_r <= S_PICK;
        end

        S_PICK: begin
          if (pick_found) begin
            copy_slot_r           <= pick_slot;
            copy_len_r            <= line_cnt_r - LCW'(1);
            copy_base_r           <= SAW'(SAW'(pick_slot) * SAW'(LINE_BYTES));
            slot_len_r[pick_slot] <= line_cnt_r - LCW'(1);
            ready_r[pick_slot]    <= 1'b1;
            ci_r                  <= '0;
            c1_valid_r            <= 1'b0;
            state_r               <= S_COPY;
          end else begin
            out_res_r.read_byte    <= 8'd0;
            out_res_r.slot_ready   <= 1'b0;
            out_res_r.ready_bits   <= ready_r;
            out_res_r.sentence_end <= 1'b1;
            out_res_r.stored_slot  <= nsc_pkg::NO_SLOT;
            out_res_r.overrun      <= 1'b0;
            out_valid_r            <= 1'b1;
            in_sent_r              <= 1'b0;
            line_cnt_r             <= '0;
            ovf_r                  <= 1'b0;
            state_r                <= S_IDLE;
          end
        end

        S_COPY: begin
          if (ci_r < copy_len_r) begin
            c1_valid_r <= 1'b1;
            c1_idx_r   <= ci_r;
            ci_r       <= ci_r + LCW'(1);
          end else begin
            c1_valid_r <= 1'b0;
          end
          if ((ci_r == copy_len_r) && !c1_valid_r) begin
            out_res_r.read_byte    <= 8'd0;
            out_res_r.slot_ready   <= 1'b0;
            out_res_r.ready_bits   <= ready_r;
            out_res_r.sentence_end <= 1'b1;
            out_res_r.stored_slot  <= {1'b0, copy_slot_r};
            out_res_r.overrun      <= 1'b0;
            out_valid_r            <= 1'b1;
            in_sent_r              <= 1'b0;
            line_cnt_r             <= '0;
            ovf_r                  <= 1'b0;
            state_r                <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r >> SLOT_COUNT) == 4'd0)
    else $error("ready bit set for a slot that does not exist");

  a_line_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r <= LCW'(LINE_BYTES))
    else $error("line count beyond buffer size");

  a_scan_in_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_PICK || state_r == S_COPY) |-> in_sent_r)
    else $error("scan or copy running outside a sentence");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd_pop)
    else $error("command taken while busy");

endmodule

[src/nmea_sentence_capture_unit.sv]
// NMEA sentence capture unit: byte stream in, one result word per input word out.
//
// Input channel (in_*): one word per received UART byte, stored-byte read or
// ready-bit clear, selected by in_tuser. Output channel (out_*): exactly one
// result word per input word, in order; out_tlast marks a word that closed a
// sentence with CR LF. Config channel (cfg_*): identifier patterns and lengths,
// always ready; write only while no input word is in flight.
//
// A two-entry command queue sits between the front end and the execution
// engine, and the output register lets the next word be queued while a result
// waits. Ordinary bytes, clears and reads past the stored length need no
// memory read in the engine; in-range reads wait for the registered slot memory
// read. A byte that ends a sentence runs a match scan over the line buffer, one
// byte per cycle, then, if a slot takes it, a copy into slot memory one byte
// per cycle; scan and copy share the single read port of the line buffer.
// Reset clears sentence state, ready bits and stored lengths and loads the
// default identifiers; no clearing pass is needed. When out_tready is low the
// result is held, the queue fills and in_tready drops.
module nmea_sentence_capture_unit #(
  parameter int LINE_BYTES    = 256,
  parameter int SLOT_COUNT    = 4,
  parameter int PATTERN_CHARS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_byte[7:0], slot[9:8], offset[17:10]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_byte[7:0], slot_ready[8], ready_bits[12:9],
                                  // stored_slot[15:13], overrun[16]
  output logic        out_tlast,  // sentence_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [55:0] cfg_data
);

  nsc_pkg::cmd_t    cmd;
  logic             cmd_valid, cmd_pop;
  nsc_pkg::res_t    res;
  nsc_pkg::cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  nsc_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  nsc_back #(
    .LINE_BYTES    (LINE_BYTES),
    .SLOT_COUNT    (SLOT_COUNT),
    .PATTERN_CHARS (PATTERN_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {7'd0, res.overrun, res.stored_slot, res.ready_bits,
                      res.slot_ready, res.read_byte};
  assign out_tlast = res.sentence_end;

endmodule

[dv/tb.sv]
// Testbench for the NMEA sentence capture unit: random sentence traffic checked against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int LINE_N = 256;
  localparam int CYCLE_LIMIT = 2_000_000;

  // Predicts the result word for each accepted input word and checks arrivals.
  class capture_scoreboard;
    logic [55:0] pat[4];
    logic [2:0]  plen[4];
    logic [7:0]  line_buf[LINE_N];
    int          line_cnt;
    bit          collecting;
    logic [7:0]  prev_byte;
    bit          line_ovf;
    logic [7:0]  slot_buf[4][LINE_N];
    int          slot_len[4];
    logic [3:0]  ready;
    nsc_pkg::res_t pending[$];
    int          errors;
    int          sentences;
    int          stored;
    int          overruns;

    function new();
      pat[0] = 56'd4671297;  pat[1] = 56'd5915713;
      pat[2] = 56'd22603022570893361; pat[3] = 56'd5393731;
      plen[0] = 3'd3; plen[1] = 3'd3; plen[2] = 3'd7; plen[3] = 3'd3;
      line_cnt = 0; collecting = 0; prev_byte = 8'd0; line_ovf = 0;
      ready = 4'd0; errors = 0; sentences = 0; stored = 0; overruns = 0;
      foreach (slot_len[i]) slot_len[i] = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [55:0] val);
      if (idx <= nsc_pkg::REG_PATTERN_D) pat[idx[1:0]] = val;
      else if (idx <= nsc_pkg::REG_LENGTH_D) plen[2'(idx - nsc_pkg::REG_LENGTH_A)] = val[2:0];
    endfunction

    function logic [7:0] id_char(int s, int k);
      return 8'(pat[s] >> (8 * (plen[s] - 1 - k)));
    endfunction

    function bit id_found(int s);
      int n;
      bit hit;
      logic [7:0] w;
      n = line_cnt + 1;
      if (plen[s] == 0 || plen[s] > n) return 0;
      for (int st = 0; st + plen[s] <= n; st++) begin
        hit = 1;
        for (int k = 0; k < plen[s]; k++) begin
          w = (st + k < line_cnt) ? line_buf[st + k] : nsc_pkg::CH_LF;
          if (w != id_char(s, k)) hit = 0;
        end
        if (hit) return 1;
      end
      return 0;
    endfunction

    function void note(nsc_pkg::mode_t m, logic [7:0] c, logic [1:0] s, logic [7:0] off);
      nsc_pkg::res_t r;
      r = '0;
      r.stored_slot = nsc_pkg::NO_SLOT;
      if (m == nsc_pkg::MODE_RX) begin
        if (c == nsc_pkg::CH_START) begin
          line_buf[0] = c; line_cnt = 1; line_ovf = 0; collecting = 1; prev_byte = c;
        end else if (collecting) begin
          if (c == nsc_pkg::CH_LF && prev_byte == nsc_pkg::CH_CR) begin
            r.sentence_end = 1;
            sentences++;
            if (line_ovf) begin
              r.overrun = 1;
              overruns++;
            end else begin
              for (int i = 0; i < 4; i++) begin
                if (id_found(i)) begin
                  for (int j = 0; j < line_cnt - 1; j++) slot_buf[i][j] = line_buf[j];
                  slot_len[i] = line_cnt - 1;
                  ready[i] = 1;
                  r.stored_slot = 3'(i);
                  stored++;
                  break;
                end
              end
            end
            collecting = 0; line_cnt = 0; line_ovf = 0;
          end else if (line_cnt < LINE_N) begin
            line_buf[line_cnt] = c;
            line_cnt++;
          end else begin
            line_ovf = 1;
          end
          prev_byte = c;
        end
      end else if (m == nsc_pkg::MODE_READ || m == nsc_pkg::MODE_CLEAR) begin
        r.slot_ready = ready[s];
        if (m == nsc_pkg::MODE_READ) begin
          if (off < slot_len[s]) r.read_byte = slot_buf[s][off];
        end else begin
          ready[s] = 0;
        end
      end
      r.ready_bits = ready;
      pending.push_back(r);
    endfunction

    function void check(nsc_pkg::res_t got);
      nsc_pkg::res_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.read_byte != e.read_byte) begin
        $error("read_byte exp %0h got %0h", e.read_byte, got.read_byte); errors++;
      end
      if (got.slot_ready != e.slot_ready) begin
        $error("slot_ready exp %0d got %0d", e.slot_ready, got.slot_ready); errors++;
      end
      if (got.ready_bits != e.ready_bits) begin
        $error("ready_bits exp %0h got %0h", e.ready_bits, got.ready_bits); errors++;
      end
      if (got.sentence_end != e.sentence_end) begin
        $error("sentence_end exp %0d got %0d", e.sentence_end, got.sentence_end); errors++;
      end
      if (got.stored_slot != e.stored_slot) begin
        $error("stored_slot exp %0d got %0d", e.stored_slot, got.stored_slot); errors++;
      end
      if (got.overrun != e.overrun) begin
        $error("overrun exp %0d got %0d", e.overrun, got.overrun); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [55:0] cfg_data;

  capture_scoreboard sb;
  bit quiet;
  int words_sent;

  nmea_sentence_capture_unit i_dut (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  task automatic send_word(nsc_pkg::mode_t m, logic [7:0] c = 8'd0, logic [1:0] s = 2'd0,
                           logic [7:0] off = 8'd0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {6'b0, off, s, c};
    do @(posedge clk); while (!in_tready);
    sb.note(m, c, s, off);
    words_sent++;
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [55:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_word(nsc_pkg::MODE_RX, t[i]);
  endtask

  // '$', random body with characters of one slot identifier dropped in at random, CR LF
  task automatic send_sentence(int body);
    int s, pos;
    logic [7:0] c;
    s = $urandom_range(0, 3);
    pos = (sb.plen[s] < body) ? $urandom_range(0, body - sb.plen[s]) : 0;
    send_word(nsc_pkg::MODE_RX, nsc_pkg::CH_START);
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 3) != 0 && i >= pos && i < pos + sb.plen[s])
        c = sb.id_char(s, i - pos);
      else if ($urandom_range(0, 9) == 0)
        c = 8'($urandom_range(0, 255));
      else
        c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == nsc_pkg::CH_START || c == nsc_pkg::CH_LF) c = 8'h2C;
      send_word(nsc_pkg::MODE_RX, c);
    end
    send_word(nsc_pkg::MODE_RX, nsc_pkg::CH_CR);
    send_word(nsc_pkg::MODE_RX, nsc_pkg::CH_LF);
  endtask

  task automatic random_traffic(int n);
    int pick, s;
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_sentence($urandom_range(0, 30));
      end else if (pick < 75) begin
        s = $urandom_range(0, 3);
        repeat ($urandom_range(1, 6))
          send_word(nsc_pkg::MODE_READ, 8'($urandom), 2'(s),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                    8'($urandom_range(0, sb.slot_len[s] + 1)));
      end else if (pick < 85) begin
        send_word(nsc_pkg::MODE_CLEAR, 8'($urandom), 2'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4))
          send_word(nsc_pkg::MODE_RX,
                    ($urandom_range(0, 3) == 0) ? nsc_pkg::CH_START : 8'($urandom));
      end else begin
        send_word(nsc_pkg::mode_t'(2'd3), 8'($urandom), 2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check(nsc_pkg::res_t'({out_tdata[7:0], out_tdata[8], out_tdata[12:9], out_tlast,
                                  out_tdata[15:13], out_tdata[16]}));
      if (!quiet && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("timeout, words outstanding: %0d", sb.pending.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    quiet = 0;
    words_sent = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= '0;
    out_tready <= 1'b0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, clear, mode 3, noise before start, restart on '$', match, slot reads and clear
    send_word(nsc_pkg::MODE_READ, 8'hFF, 2'd3, 8'hFF);
    send_word(nsc_pkg::MODE_READ, 8'h00, 2'd0, 8'h00);
    send_word(nsc_pkg::mode_t'(2'd3), 8'hFF, 2'd3, 8'hFF);
    send_word(nsc_pkg::MODE_CLEAR, 8'h00, 2'd3, 8'h00);
    send_word(nsc_pkg::MODE_RX, 8'hFF);
    send_word(nsc_pkg::MODE_RX, 8'h00);
    send_text("$X$GPGGA,\r\n");
    send_word(nsc_pkg::MODE_READ, 8'h00, 2'd0, 8'd0);
    send_word(nsc_pkg::MODE_READ, 8'h00, 2'd0, 8'd7);
    send_word(nsc_pkg::MODE_CLEAR, 8'h00, 2'd0, 8'h00);
    send_word(nsc_pkg::MODE_READ, 8'h00, 2'd0, 8'd5);
    drain();

    random_traffic(420);
    // line buffer overflow: body longer than the buffer
    send_word(nsc_pkg::MODE_RX, nsc_pkg::CH_START);
    repeat (LINE_N + 6) send_word(nsc_pkg::MODE_RX, 8'h41);
    send_text("\r\n");
    drain();

    write_cfg(nsc_pkg::REG_PATTERN_A, 56'h2C);
    write_cfg(nsc_pkg::REG_LENGTH_A, 56'd1);
    write_cfg(nsc_pkg::REG_PATTERN_B, {8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C, 8'h0D});
    write_cfg(nsc_pkg::REG_LENGTH_B, 56'd7);
    write_cfg(nsc_pkg::REG_LENGTH_C, 56'd0);
    write_cfg(nsc_pkg::REG_PATTERN_D, 56'hFF_FFFF_FFFF_0D0A);
    write_cfg(nsc_pkg::REG_LENGTH_D, 56'd2);
    write_cfg(4'd9, 56'h123);
    cfg_valid <= 1'b0;
    random_traffic(500);
    drain();

    write_cfg(nsc_pkg::REG_PATTERN_A, 56'hFF_FFFF_FFFF_FFFF);
    write_cfg(nsc_pkg::REG_LENGTH_A, 56'd7);
    write_cfg(nsc_pkg::REG_PATTERN_B, 56'h0);
    write_cfg(nsc_pkg::REG_LENGTH_B, 56'd1);
    write_cfg(nsc_pkg::REG_PATTERN_C, {32'h0, 8'h24, 8'h47, 8'h4E});
    write_cfg(nsc_pkg::REG_LENGTH_C, 56'd3);
    write_cfg(nsc_pkg::REG_PATTERN_D, 56'({$urandom, $urandom}) & 56'h7F_7F7F_7F7F_7F7F);
    write_cfg(nsc_pkg::REG_LENGTH_D, 56'($urandom_range(1, 7)));
    cfg_valid <= 1'b0;
    random_traffic(400);
    quiet = 1;
    random_traffic(300);
    drain();

    $display("%0d words, %0d sentences, %0d stored, %0d overruns over three id sets",
             words_sent, sb.sentences, sb.stored, sb.overruns);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
